// File: src/lrutlb_pkg.sv
// Shared types and field widths for the LRU translation buffer.
`default_nettype none

package lrutlb_pkg;

    localparam int unsigned PidW  = 16;
    localparam int unsigned KeyW  = 32;
    localparam int unsigned PhysW = 32;

    // Action codes of an input item.
    typedef enum logic {
        ACT_LOOKUP = 1'b0,
        ACT_INSERT = 1'b1
    } t_action;

    // One buffer entry as it moves along the chain.
    typedef struct packed {
        logic             valid;
        logic [PidW-1:0]  process_id;
        logic [KeyW-1:0]  virtual_key;
        logic [PhysW-1:0] physical;
    } t_entry;

    // Probe broadcast to every cell for the item in flight.
    typedef struct packed {
        logic             update;
        logic [PidW-1:0]  process_id;
        logic [KeyW-1:0]  virtual_key;
    } t_probe;

endpackage

`default_nettype wire

// File: src/lrutlb_cell.sv
// One recency slot of the buffer: tag compare and shift toward the tail.
`default_nettype none

module lrutlb_cell (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire lrutlb_pkg::t_probe            i_probe,
    input  wire lrutlb_pkg::t_entry            i_prev,
    input  wire logic                          i_older,
    input  wire logic [lrutlb_pkg::PhysW-1:0]  i_acc,
    output lrutlb_pkg::t_entry                 o_entry,
    output logic                               o_older,
    output logic [lrutlb_pkg::PhysW-1:0]       o_acc,
    output logic                               o_match
);

    logic                          r_valid;
    logic                          n_valid;
    logic [lrutlb_pkg::PidW-1:0]   r_pid;
    logic [lrutlb_pkg::KeyW-1:0]   r_key;
    logic [lrutlb_pkg::PhysW-1:0]  r_phys;
    logic                          shift;

    assign o_match = r_valid && (r_pid == i_probe.process_id)
                     && (r_key == i_probe.virtual_key);
    assign o_older = o_match | i_older;
    assign o_acc   = i_acc | (o_match ? r_phys : '0);
    // Take the neighbor's entry when the promoted slot sits here or further back.
    assign shift   = i_probe.update & o_older;
    assign n_valid = shift ? i_prev.valid : r_valid;

    assign o_entry.valid       = r_valid;
    assign o_entry.process_id  = r_pid;
    assign o_entry.virtual_key = r_key;
    assign o_entry.physical    = r_phys;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (shift) begin
            r_pid  <= i_prev.process_id;
            r_key  <= i_prev.virtual_key;
            r_phys <= i_prev.physical;
        end
    end

endmodule

`default_nettype wire

// File: src/lru_translation_lookaside_buffer_unit.sv
// Top level of the fully associative LRU translation buffer.
//
// A fully associative translation buffer of ENTRIES entries kept as a chain
// of cells ordered by recency: cell 0 holds the most recently used entry and
// the last cell the least recently used one. Each item is a lookup (action 0)
// or an insert/update (action 1), keyed by process id and virtual key. All
// cells compare their tags in parallel. A hit, or any insert, promotes an
// entry to cell 0 while every cell in front of it moves one place back; an
// insert that misses drops the entry in the last cell. Entries start invalid.
// The block takes one item per clock cycle while not stalled, and each result
// appears in the output register in the cycle after the item is accepted; the
// whole compare, select and shift of the chain completes with that acceptance.
// The output register frees the input side: a new item is taken whenever the
// output register is empty or its result is taken in the same cycle. Input
// stall is high while reset is asserted.
`default_nettype none

module lru_translation_lookaside_buffer_unit #(
    parameter int unsigned ENTRIES = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_action,
    input  wire logic [lrutlb_pkg::PidW-1:0]   i_process_id,
    input  wire logic [lrutlb_pkg::KeyW-1:0]   i_virtual_key,
    input  wire logic [lrutlb_pkg::PhysW-1:0]  i_physical_value,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic                               o_hit,
    output logic [lrutlb_pkg::PhysW-1:0]       o_physical_out
);

    lrutlb_pkg::t_entry                 cell_entry [ENTRIES];
    logic                               cell_older [ENTRIES+1];
    logic [lrutlb_pkg::PhysW-1:0]       cell_acc   [ENTRIES+1];
    logic [ENTRIES-1:0]                 cell_match;

    lrutlb_pkg::t_probe                 probe;
    lrutlb_pkg::t_entry                 head;
    logic                               accept;
    logic                               hit;
    logic                               is_insert;

    logic                               r_out_valid;
    logic                               n_out_valid;
    logic                               r_hit;
    logic [lrutlb_pkg::PhysW-1:0]       r_phys;

    // Hold the input while the result register is full and stalled.
    assign o_stall   = !i_rst_n || (r_out_valid && i_stall);
    assign accept    = i_valid && !o_stall;
    assign is_insert = (lrutlb_pkg::t_action'(i_action) == lrutlb_pkg::ACT_INSERT);
    assign hit       = |cell_match;

    // Any hit or any insert promotes; a lookup miss leaves the chain alone.
    assign probe.update      = accept && (hit || is_insert);
    assign probe.process_id  = i_process_id;
    assign probe.virtual_key = i_virtual_key;

    // New head: the matched entry, with the new physical value on insert.
    assign head.valid       = 1'b1;
    assign head.process_id  = i_process_id;
    assign head.virtual_key = i_virtual_key;
    assign head.physical    = is_insert ? i_physical_value : cell_acc[0];

    // On an insert miss the whole chain advances and the tail entry drops off.
    assign cell_older[ENTRIES] = !hit;
    assign cell_acc[ENTRIES]   = '0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lrutlb_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_probe (probe),
            .i_prev  ((g == 0) ? head : cell_entry[(g == 0) ? 0 : g-1]),
            .i_older (cell_older[g+1]),
            .i_acc   (cell_acc[g+1]),
            .o_entry (cell_entry[g]),
            .o_older (cell_older[g]),
            .o_acc   (cell_acc[g]),
            .o_match (cell_match[g])
        );
    end

    assign n_out_valid = accept || (r_out_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Capture the result of the accepted item.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hit  <= hit;
            r_phys <= (hit && !is_insert) ? cell_acc[0] : '0;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_hit          = r_hit;
    assign o_physical_out = r_phys;

endmodule

`default_nettype wire

// File: src/lrutlb_checker.sv
// Port-level checks for the LRU translation buffer, bound to the top level.
`default_nettype none

module lrutlb_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_valid,
    input wire logic                          o_stall,
    input wire logic                          i_action,
    input wire logic [lrutlb_pkg::PidW-1:0]   i_process_id,
    input wire logic [lrutlb_pkg::KeyW-1:0]   i_virtual_key,
    input wire logic [lrutlb_pkg::PhysW-1:0]  i_physical_value,
    input wire logic                          o_valid,
    input wire logic                          i_stall,
    input wire logic                          o_hit,
    input wire logic [lrutlb_pkg::PhysW-1:0]  o_physical_out
);

    logic in_acc;
    assign in_acc = i_valid && !o_stall;

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_hit) && $stable(o_physical_out))
        else $error("stalled result changed");

    // An accepted item shows its result in the next cycle.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_valid)
        else $error("accepted item produced no result");

    // A taken result with no new item leaves the output empty.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !in_acc |=> !o_valid)
        else $error("result repeated");

    // A miss never carries a physical value.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> o_physical_out == '0)
        else $error("miss with nonzero physical value");

    // A lookup right after an insert of the same key hits with the new value.
    a_insert_then_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_action == lrutlb_pkg::ACT_LOOKUP) && $past(i_rst_n) && $past(in_acc)
        && ($past(i_action) == lrutlb_pkg::ACT_INSERT)
        && (i_process_id == $past(i_process_id))
        && (i_virtual_key == $past(i_virtual_key))
        |=> o_hit && (o_physical_out == $past(i_physical_value, 2)))
        else $error("lookup after insert missed");

endmodule

bind lru_translation_lookaside_buffer_unit lrutlb_checker u_lrutlb_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_stall          (o_stall),
    .i_action         (i_action),
    .i_process_id     (i_process_id),
    .i_virtual_key    (i_virtual_key),
    .i_physical_value (i_physical_value),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_hit            (o_hit),
    .o_physical_out   (o_physical_out)
);

`default_nettype wire

// File: tb/tb_lru_translation_lookaside_buffer_unit.sv
// Self-checking testbench for the LRU translation buffer: directed and random lookups and inserts.
`default_nettype none

module tb_lru_translation_lookaside_buffer_unit;
    import lrutlb_pkg::*;

    localparam int unsigned TLB_DEPTH      = 16;
    localparam int unsigned RANK_W         = $clog2(TLB_DEPTH);
    localparam int unsigned RANDOM_ITEMS   = 800;
    localparam int unsigned QUIET_TAIL     = 80;    // last items go with no idling
    localparam int unsigned RATE_PERIOD    = 150;   // cycles between idle-rate changes
    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned DRAIN_CYCLES   = 16;

    // One request to the buffer, plus a flag that holds the sender until
    // every outstanding result has come back.
    typedef struct {
        t_action          action;
        logic [PidW-1:0]  pid;
        logic [KeyW-1:0]  vkey;
        logic [PhysW-1:0] phys;
        bit               drain_first;
    } tlb_req_t;

    typedef struct {
        logic             hit;
        logic [PhysW-1:0] phys;
    } tlb_resp_t;

    logic             i_clk            = 1'b0;
    logic             i_rst_n          = 1'b0;
    logic             i_valid          = 1'b0;
    logic             i_action         = 1'b0;
    logic [PidW-1:0]  i_process_id     = '0;
    logic [KeyW-1:0]  i_virtual_key    = '0;
    logic [PhysW-1:0] i_physical_value = '0;
    logic             i_stall          = 1'b0;
    logic             o_stall;
    logic             o_valid;
    logic             o_hit;
    logic [PhysW-1:0] o_physical_out;

    // Shadow copy of the buffer contents and recency order (rank 0 = newest).
    logic             shadow_valid [TLB_DEPTH];
    logic [PidW-1:0]  shadow_pid   [TLB_DEPTH];
    logic [KeyW-1:0]  shadow_vkey  [TLB_DEPTH];
    logic [PhysW-1:0] shadow_phys  [TLB_DEPTH];
    logic [RANK_W-1:0] shadow_rank [TLB_DEPTH];

    tlb_req_t  request_q[$];            // items not yet presented
    tlb_resp_t pending_translations[$]; // results owed by the block, oldest first
    tlb_req_t  cur_req;

    int unsigned total_items    = 0;
    int unsigned accepted_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned send_gap       = 0;
    int unsigned stall_left     = 0;
    int unsigned idle_rate      = 0;    // percent chance to start an idle burst

    lru_translation_lookaside_buffer_unit #(
        .ENTRIES(TLB_DEPTH)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_action        (i_action),
        .i_process_id    (i_process_id),
        .i_virtual_key   (i_virtual_key),
        .i_physical_value(i_physical_value),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_hit           (o_hit),
        .o_physical_out  (o_physical_out)
    );

    always #4 i_clk = ~i_clk;

    // Move an entry to rank 0; every entry newer than it ages by one.
    function automatic void promote_entry(int slot);
        logic [RANK_W-1:0] old_rank;
        old_rank = shadow_rank[slot];
        for (int j = 0; j < TLB_DEPTH; j++) begin
            if (shadow_rank[j] < old_rank) begin
                shadow_rank[j] = shadow_rank[j] + 1'b1;
            end
        end
        shadow_rank[slot] = '0;
    endfunction

    // Compute the result of one request and advance the shadow buffer.
    function automatic tlb_resp_t translate(tlb_req_t r);
        tlb_resp_t resp;
        int        slot;
        resp.hit  = 1'b0;
        resp.phys = '0;
        slot      = -1;
        for (int j = 0; j < TLB_DEPTH; j++) begin
            if (shadow_valid[j] && shadow_pid[j] == r.pid && shadow_vkey[j] == r.vkey) begin
                slot = j;
            end
        end
        resp.hit = (slot >= 0);
        if (r.action == ACT_LOOKUP) begin
            if (slot >= 0) begin
                resp.phys = shadow_phys[slot];
                promote_entry(slot);
            end
        end else begin
            if (slot < 0) begin
                // Miss: take over the least recently used entry.
                slot = 0;
                for (int j = 1; j < TLB_DEPTH; j++) begin
                    if (shadow_rank[j] > shadow_rank[slot]) begin
                        slot = j;
                    end
                end
                shadow_valid[slot] = 1'b1;
                shadow_pid[slot]   = r.pid;
                shadow_vkey[slot]  = r.vkey;
            end
            shadow_phys[slot] = r.phys;
            promote_entry(slot);
        end
        return resp;
    endfunction

    task automatic queue_request(t_action act, logic [PidW-1:0] pid, logic [KeyW-1:0] vkey,
                                 logic [PhysW-1:0] phys, bit drain_first);
        tlb_req_t r;
        r.action      = act;
        r.pid         = pid;
        r.vkey        = vkey;
        r.phys        = phys;
        r.drain_first = drain_first;
        request_q.push_back(r);
        total_items++;
    endtask

    // Sender: hold a stalled item, otherwise present the next one or idle.
    // The idle rate is picked here for both sides and drops to zero near the end.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid   <= 1'b0;
            idle_rate <= 0;
        end else begin
            cycle_count++;
            if (request_q.size() < QUIET_TAIL) begin
                idle_rate <= 0;
            end else if (cycle_count % RATE_PERIOD == 0) begin
                case ($urandom_range(0, 3))
                    0:       idle_rate <= 0;
                    1:       idle_rate <= 5;
                    2:       idle_rate <= 20;
                    default: idle_rate <= 40;
                endcase
            end

            if (i_valid && !o_stall) begin
                pending_translations.push_back(translate(cur_req));
                accepted_count++;
            end

            if (!(i_valid && o_stall)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (request_q.size() == 0 ||
                             (request_q[0].drain_first && pending_translations.size() != 0)) begin
                    // Nothing left, or wait for the block to empty out.
                    i_valid <= 1'b0;
                end else if ($urandom_range(0, 99) < idle_rate) begin
                    send_gap = $urandom_range(0, 9);
                    i_valid <= 1'b0;
                end else begin
                    cur_req = request_q.pop_front();
                    i_valid          <= 1'b1;
                    i_action         <= cur_req.action;
                    i_process_id     <= cur_req.pid;
                    i_virtual_key    <= cur_req.vkey;
                    i_physical_value <= cur_req.phys;
                end
            end
        end
    end

    // Receiver: check each accepted result against the oldest expectation,
    // then decide whether to stall the next cycle.
    always @(posedge i_clk) begin
        tlb_resp_t exp_resp;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (pending_translations.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual hit=%0b phys=%08h",
                             $time, o_hit, o_physical_out);
                    mismatch_count++;
                end else begin
                    exp_resp = pending_translations.pop_front();
                    if (o_hit !== exp_resp.hit) begin
                        $display("%0t: hit mismatch, expected %0b, actual %0b",
                                 $time, exp_resp.hit, o_hit);
                        mismatch_count++;
                    end
                    if (o_physical_out !== exp_resp.phys) begin
                        $display("%0t: physical_out mismatch, expected %08h, actual %08h",
                                 $time, exp_resp.phys, o_physical_out);
                        mismatch_count++;
                    end
                end
            end

            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if ($urandom_range(0, 99) < idle_rate) begin
                stall_left = $urandom_range(0, 9);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog: end the run if no item moves on either side for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        logic [PidW-1:0] pid_pool [4];
        logic [KeyW-1:0] key_pool [64];
        int unsigned     pool_size;
        int unsigned     k;
        t_action         act;
        logic [PidW-1:0] pid;
        logic [KeyW-1:0] vkey;

        for (int j = 0; j < TLB_DEPTH; j++) begin
            shadow_valid[j] = 1'b0;
            shadow_pid[j]   = '0;
            shadow_vkey[j]  = '0;
            shadow_phys[j]  = '0;
            shadow_rank[j]  = RANK_W'(j);
        end

        // Directed: lookup into an empty buffer, field extremes, an update
        // that hits, the same key under another process, then enough new
        // inserts to evict the two oldest entries.
        queue_request(ACT_LOOKUP, '1, '1, '1, 1'b0);
        queue_request(ACT_INSERT, '0, '0, '1, 1'b0);
        queue_request(ACT_INSERT, '1, '1, '0, 1'b0);
        queue_request(ACT_LOOKUP, '0, '0, '0, 1'b0);
        queue_request(ACT_LOOKUP, '1, '0, '1, 1'b0);
        queue_request(ACT_LOOKUP, '0, '1, '0, 1'b0);
        queue_request(ACT_INSERT, '0, '0, 32'h1234_5678, 1'b0);
        queue_request(ACT_LOOKUP, '0, '0, '0, 1'b0);
        for (int i = 0; i < TLB_DEPTH; i++) begin
            queue_request(ACT_INSERT, 16'h0001, 32'h100 + i, $urandom(), 1'b0);
        end
        queue_request(ACT_LOOKUP, '1, '1, '0, 1'b0);
        queue_request(ACT_LOOKUP, 16'h0001, 32'h100, '0, 1'b0);

        // Random: keys come from a pool whose size changes every hundred
        // items, so the working set sometimes fits and sometimes thrashes.
        // A few items use a foreign process id together with a wholly random key.
        pool_size = 16;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                case ($urandom_range(0, 5))
                    0:       pool_size = 4;
                    1:       pool_size = 12;
                    2:       pool_size = 16;
                    3:       pool_size = 17;
                    4:       pool_size = 24;
                    default: pool_size = 48;
                endcase
                for (int p = 0; p < 4; p++) begin
                    pid_pool[p] = $urandom_range(0, 65535);
                end
                for (int q = 0; q < 64; q++) begin
                    key_pool[q] = $urandom();
                end
            end
            act = ($urandom_range(0, 9) < 6) ? ACT_LOOKUP : ACT_INSERT;
            k   = $urandom_range(0, pool_size - 1);
            if ($urandom_range(0, 9) == 0) begin
                pid  = $urandom_range(0, 65535);
                vkey = $urandom();
            end else begin
                pid  = ($urandom_range(0, 7) == 0) ? pid_pool[$urandom_range(0, 3)]
                                                    : pid_pool[k % 4];
                vkey = key_pool[k];
            end
            queue_request(act, pid, vkey, $urandom(), (n % 300) == 0);
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every item to be taken and every result to come back.
        do begin
            @(posedge i_clk);
        end while (accepted_count < total_items || pending_translations.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_translations.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire
